@@ rtl/core/pva_pkg.sv @@
// Shared constants, types and a helper function for the priority voice allocator.
`timescale 1ns / 1ps

package pva_pkg;

    // Channel organization.
    localparam int NUM_CHANNELS = 16;
    localparam int CH_W         = $clog2(NUM_CHANNELS);
    localparam int CNT_W        = CH_W + 1;

    // Field widths.
    localparam int PRIO_W = 8;
    localparam int VOL_W  = 7;
    localparam int PAN_W  = 7;
    localparam int OVOL_W = 8;

    // Surround volume arithmetic.
    localparam int BASE_VOLUME    = 96;
    localparam int PAN_SHIFT      = 2;
    localparam int VOL_NORM_SHIFT = 5;
    localparam int VOL_NORMALIZE  = 1 << VOL_NORM_SHIFT;
    localparam int PAN_CENTRE     = 64;
    localparam int PAN_RIGHT      = 127;
    localparam int VOL_FULL       = 127;
    localparam int VOL_MAX        = 255;

    // Division by VOL_FULL as a multiply by 129 / 2^14 plus one correction step.
    localparam int RECIP_MUL   = 129;
    localparam int RECIP_SHIFT = 14;
    localparam int PROD_W      = 2 * VOL_W;
    localparam int REM_W       = PROD_W + 2;

    // Shared multiplier operand and product widths.
    localparam int MUL_A_W = PROD_W + 1;
    localparam int MUL_B_W = PAN_W + 2;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;

    // Item function codes.
    localparam logic FUNC_PLAY = 1'b0;
    localparam logic FUNC_END  = 1'b1;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_EIGHT    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SURROUND = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MP3      = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DECIDE,
        ST_MUL_SV,
        ST_DIV,
        ST_CORR,
        ST_MUL_DIFF,
        ST_MIX,
        ST_DONE
    } pva_state_t;

    // Clamp a signed volume to the 0..255 range of the channel volume register.
    function automatic logic [OVOL_W-1:0] clamp_vol(input logic signed [MUL_P_W-1:0] v);
        logic [OVOL_W-1:0] r;
        if (v < 0)
            r = '0;
        else if (v > MUL_P_W'(VOL_MAX))
            r = OVOL_W'(VOL_MAX);
        else
            r = v[OVOL_W-1:0];
        return r;
    endfunction

endpackage

@@ rtl/core/priority_voice_allocator.sv @@
// Top level of the priority voice allocator: channel scan, sequencer and volume split.
// A play word's result follows the scan of all 16 channels (one channel per cycle), a
// decision step and, in surround, three multiplier passes, a quotient correction and a
// mix step; a channel-ended word goes straight to its result. One word is in flight at
// a time. Reset clears configuration, busy marks and sequencer; priorities stay.
`timescale 1ns / 1ps

module priority_voice_allocator (
    input  logic                             clk,
    input  logic                             rst_n,
    // Configuration write port.
    input  logic                             cfg_we,
    input  logic [pva_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic                             cfg_data,
    // Input channel.
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic                             func,
    input  logic [pva_pkg::PRIO_W-1:0]       request_priority,
    input  logic [pva_pkg::VOL_W-1:0]        request_volume,
    input  logic [pva_pkg::PAN_W-1:0]        request_pan,
    input  logic [pva_pkg::CH_W-1:0]         ended_channel,
    // Output channel.
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic                             granted,
    output logic [pva_pkg::CH_W-1:0]         channel,
    output logic [pva_pkg::OVOL_W-1:0]       front_volume,
    output logic [pva_pkg::PAN_W-1:0]        front_pan,
    output logic                             rear_valid,
    output logic [pva_pkg::CH_W-1:0]         rear_channel,
    output logic [pva_pkg::OVOL_W-1:0]       rear_volume,
    output logic [pva_pkg::PAN_W-1:0]        rear_pan
);
    import pva_pkg::*;

    // Configuration registers.
    logic eight_reg;
    logic surround_reg;
    logic mp3_reg;

    // Channel state: busy marks are reset, priorities are written before use.
    logic [NUM_CHANNELS-1:0] busy_reg;
    logic [PRIO_W-1:0]       prio_mem [NUM_CHANNELS];

    // Sequencer.
    pva_state_t state_reg, state_next;

    // Latched request.
    logic [PRIO_W-1:0] req_prio_reg;
    logic [VOL_W-1:0]  vol_reg;
    logic [PAN_W-1:0]  pan_reg;

    // Scan results.
    logic [CH_W-1:0]   scan_idx_reg;
    logic              free_found_reg;
    logic [CH_W-1:0]   free_idx_reg;
    logic              min_found_reg;
    logic [CH_W-1:0]   min_idx_reg;
    logic [PRIO_W-1:0] min_prio_reg;

    // Volume datapath.
    logic [CNT_W-1:0]  partner_reg;
    logic [PROD_W-1:0] x_reg;
    logic [VOL_W-1:0]  sv_reg;

    // Result registers.
    logic              granted_reg;
    logic [CH_W-1:0]   channel_reg;
    logic [OVOL_W-1:0] front_volume_reg;
    logic [PAN_W-1:0]  front_pan_reg;
    logic              rear_valid_reg;
    logic [CH_W-1:0]   rear_channel_reg;
    logic [OVOL_W-1:0] rear_volume_reg;
    logic [PAN_W-1:0]  rear_pan_reg;

    logic in_fire;
    logic out_fire;

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = (state_reg == ST_DONE);
    assign in_fire   = in_valid && in_ready;
    assign out_fire  = out_valid && out_ready;

    // ------------------------------------------------------------------
    // Reserved mask. The usable count is 16 or 8; surround reserves the
    // upper half of the usable channels, and the MP3 stream takes channel 0
    // plus either its surround partner or channel 1.
    // ------------------------------------------------------------------
    logic [CNT_W-1:0]        usable_cnt;
    logic [CNT_W-1:0]        half_cnt;
    logic [NUM_CHANNELS-1:0] res_mask;

    assign usable_cnt = eight_reg ? CNT_W'(NUM_CHANNELS / 2) : CNT_W'(NUM_CHANNELS);
    assign half_cnt   = usable_cnt >> 1;

    always_comb
    begin
        for (int i = 0; i < NUM_CHANNELS; i++)
        begin
            res_mask[i] = (CNT_W'(i) >= usable_cnt)
                        || (surround_reg && (CNT_W'(i) >= half_cnt)
                            && (CNT_W'(i) < usable_cnt))
                        || (mp3_reg && ((i == 0)
                            || (CNT_W'(i) == (surround_reg ? half_cnt : CNT_W'(1)))));
        end
    end

    // ------------------------------------------------------------------
    // Scan step: one channel per cycle. The last free channel seen is the
    // highest-numbered one; a strict less-than keeps the first channel of
    // the lowest priority.
    // ------------------------------------------------------------------
    logic [PRIO_W-1:0] cur_prio;
    logic              cur_avail;
    logic              cur_free;
    logic              cur_better;

    assign cur_prio   = prio_mem[scan_idx_reg];
    assign cur_avail  = !res_mask[scan_idx_reg];
    assign cur_free   = cur_avail && !busy_reg[scan_idx_reg];
    assign cur_better = cur_avail && (!min_found_reg || (cur_prio < min_prio_reg));

    // Decision after the scan.
    logic            grant_ok;
    logic [CH_W-1:0] pick;

    assign grant_ok = free_found_reg || (min_found_reg && (min_prio_reg <= req_prio_reg));
    assign pick     = free_found_reg ? free_idx_reg : min_idx_reg;

    // ------------------------------------------------------------------
    // Shared multiplier. It computes in turn vol * BASE_VOLUME, that
    // product times the reciprocal of 127, and finally off * sv.
    // ------------------------------------------------------------------
    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [MUL_P_W-1:0] mul_p;
    logic signed [MUL_B_W-1:0] pan_off;

    // The pan offset is floored, which an arithmetic shift gives directly.
    assign pan_off = ($signed(MUL_B_W'(pan_reg)) - MUL_B_W'(PAN_CENTRE)) >>> PAN_SHIFT;

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            ST_MUL_SV:
            begin
                mul_a = MUL_A_W'(vol_reg);
                mul_b = MUL_B_W'(BASE_VOLUME);
            end
            ST_DIV:
            begin
                mul_a = MUL_A_W'(mul_p[PROD_W-1:0]);
                mul_b = MUL_B_W'(RECIP_MUL);
            end
            ST_MUL_DIFF:
            begin
                mul_a = MUL_A_W'(sv_reg);
                mul_b = pan_off;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    pva_mul u_mul (
        .clk (clk),
        .a   (mul_a),
        .b   (mul_b),
        .p   (mul_p)
    );

    // Quotient estimate is at most one short; one compare fixes it.
    logic [VOL_W-1:0] q_est;
    logic [REM_W-1:0] q_rem;

    assign q_est = mul_p[RECIP_SHIFT +: VOL_W];
    assign q_rem = REM_W'(x_reg) - ((REM_W'(q_est) << VOL_W) - REM_W'(q_est));

    // Front and rear split; the difference is truncated toward zero.
    logic signed [MUL_P_W-1:0] diff_round;
    logic signed [MUL_P_W-1:0] diff_val;
    logic signed [MUL_P_W-1:0] sv_ext;

    assign diff_round = (mul_p < 0) ? (mul_p + MUL_P_W'(VOL_NORMALIZE - 1)) : mul_p;
    assign diff_val   = diff_round >>> VOL_NORM_SHIFT;
    assign sv_ext     = $signed(MUL_P_W'(sv_reg));

    // ------------------------------------------------------------------
    // Sequencer.
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                    state_next = (func == FUNC_END) ? ST_DONE : ST_SCAN;
            end
            ST_SCAN:
            begin
                if (scan_idx_reg == CH_W'(NUM_CHANNELS - 1))
                    state_next = ST_DECIDE;
            end
            ST_DECIDE:
            begin
                if (grant_ok && surround_reg)
                    state_next = ST_MUL_SV;
                else
                    state_next = ST_DONE;
            end
            ST_MUL_SV:   state_next = ST_DIV;
            ST_DIV:      state_next = ST_CORR;
            ST_CORR:     state_next = ST_MUL_DIFF;
            ST_MUL_DIFF: state_next = ST_MIX;
            ST_MIX:      state_next = ST_DONE;
            ST_DONE:
            begin
                if (out_fire)
                    state_next = ST_IDLE;
            end
            default:     state_next = ST_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // Control state: configuration, busy marks, scan flags.
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            eight_reg      <= 1'b0;
            surround_reg   <= 1'b0;
            mp3_reg        <= 1'b0;
            busy_reg       <= '0;
            scan_idx_reg   <= '0;
            free_found_reg <= 1'b0;
            min_found_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_EIGHT:    eight_reg    <= cfg_data;
                    CFG_SURROUND: surround_reg <= cfg_data;
                    CFG_MP3:      mp3_reg      <= cfg_data;
                    default:      ;
                endcase
            end

            if (in_fire)
            begin
                scan_idx_reg   <= '0;
                free_found_reg <= 1'b0;
                min_found_reg  <= 1'b0;
                if ((func == FUNC_END) && (CNT_W'(ended_channel) < CNT_W'(NUM_CHANNELS)))
                    busy_reg[ended_channel] <= 1'b0;
            end

            if (state_reg == ST_SCAN)
            begin
                scan_idx_reg <= scan_idx_reg + CH_W'(1);
                if (cur_free)
                    free_found_reg <= 1'b1;
                if (cur_better)
                    min_found_reg <= 1'b1;
            end

            if ((state_reg == ST_DECIDE) && grant_ok)
                busy_reg[pick] <= 1'b1;

            // The surround partner is marked in the cycle after the front channel.
            if ((state_reg == ST_MUL_SV) && (partner_reg < CNT_W'(NUM_CHANNELS)))
                busy_reg[partner_reg[CH_W-1:0]] <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Payload: request latch, priority store, scan data, volume path and
    // result words.
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            req_prio_reg     <= request_priority;
            vol_reg          <= request_volume;
            pan_reg          <= request_pan;
            granted_reg      <= 1'b0;
            channel_reg      <= '0;
            front_volume_reg <= '0;
            front_pan_reg    <= '0;
            rear_valid_reg   <= 1'b0;
            rear_channel_reg <= '0;
            rear_volume_reg  <= '0;
            rear_pan_reg     <= '0;
        end

        if (state_reg == ST_SCAN)
        begin
            if (cur_free)
                free_idx_reg <= scan_idx_reg;
            if (cur_better)
            begin
                min_idx_reg  <= scan_idx_reg;
                min_prio_reg <= cur_prio;
            end
        end

        if ((state_reg == ST_DECIDE) && grant_ok)
        begin
            prio_mem[pick] <= req_prio_reg;
            partner_reg    <= CNT_W'(pick) + half_cnt;
            granted_reg    <= 1'b1;
            channel_reg    <= pick;
            if (surround_reg)
            begin
                rear_valid_reg   <= 1'b1;
                rear_channel_reg <= CH_W'(CNT_W'(pick) + half_cnt);
                rear_pan_reg     <= PAN_W'(PAN_RIGHT);
                front_pan_reg    <= '0;
            end
            else
            begin
                front_volume_reg <= OVOL_W'(vol_reg);
                front_pan_reg    <= pan_reg;
            end
        end

        if ((state_reg == ST_MUL_SV) && (partner_reg < CNT_W'(NUM_CHANNELS)))
            prio_mem[partner_reg[CH_W-1:0]] <= req_prio_reg;

        if (state_reg == ST_DIV)
            x_reg <= mul_p[PROD_W-1:0];

        if (state_reg == ST_CORR)
            sv_reg <= (q_rem >= REM_W'(VOL_FULL)) ? (q_est + VOL_W'(1)) : q_est;

        if (state_reg == ST_MIX)
        begin
            front_volume_reg <= clamp_vol(sv_ext + diff_val);
            rear_volume_reg  <= clamp_vol(sv_ext - diff_val);
        end
    end

    assign granted      = granted_reg;
    assign channel      = channel_reg;
    assign front_volume = front_volume_reg;
    assign front_pan    = front_pan_reg;
    assign rear_valid   = rear_valid_reg;
    assign rear_channel = rear_channel_reg;
    assign rear_volume  = rear_volume_reg;
    assign rear_pan     = rear_pan_reg;

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------

    // Only one word is in flight: no new word is taken while a result waits.
    a_single_word: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> !out_valid)
        else $error("input ready while a result is pending");

    // A granted channel is marked busy by the time its result is offered.
    a_grant_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && granted) |-> busy_reg[channel])
        else $error("granted channel not marked busy");

    // A surround partner only appears together with a granted front channel.
    a_rear_grant: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && rear_valid) |-> (granted && surround_reg))
        else $error("rear channel without a surround grant");

    // The scan always ends in the decision step.
    a_scan_end: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_SCAN) && (scan_idx_reg == CH_W'(NUM_CHANNELS - 1)))
        |=> (state_reg == ST_DECIDE))
        else $error("channel scan did not end in the decision step");

endmodule

@@ rtl/core/pva_mul.sv @@
// Shared signed multiplier with a registered product.
`timescale 1ns / 1ps

module pva_mul (
    input  logic                                 clk,
    input  logic signed [pva_pkg::MUL_A_W-1:0]   a,
    input  logic signed [pva_pkg::MUL_B_W-1:0]   b,
    output logic signed [pva_pkg::MUL_P_W-1:0]   p
);
    import pva_pkg::*;

    logic signed [MUL_P_W-1:0] p_reg;

    always_ff @(posedge clk)
    begin
        p_reg <= MUL_P_W'(a) * MUL_P_W'(b);
    end

    assign p = p_reg;

endmodule

@@ tb/tb_top.sv @@
// Self-checking testbench for the priority voice allocator: random and directed words, scoreboarded.
`timescale 1ns / 1ps

module tb_top;

    import pva_pkg::*;

    // Write to the one index that maps to no register; the block must ignore it.
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    localparam int NUM_PHASES     = 12;
    localparam int WORDS_PER_PHASE = 85;
    // Idle time after draining, enough to cover any work still under way.
    localparam int SETTLE_CYCLES  = 30;
    // Time limit far beyond the slowest correct run.
    localparam int TIMEOUT_NS     = 20_000_000;

    // One word on the input channel.
    typedef struct packed {
        logic              func;
        logic [PRIO_W-1:0] prio;
        logic [VOL_W-1:0]  vol;
        logic [PAN_W-1:0]  pan;
        logic [CH_W-1:0]   ended;
    } voice_word_t;

    // One word on the output channel.
    typedef struct packed {
        logic              granted;
        logic [CH_W-1:0]   channel;
        logic [OVOL_W-1:0] front_volume;
        logic [PAN_W-1:0]  front_pan;
        logic              rear_valid;
        logic [CH_W-1:0]   rear_channel;
        logic [OVOL_W-1:0] rear_volume;
        logic [PAN_W-1:0]  rear_pan;
    } voice_grant_t;

    // Clock, reset and every block input start at known values.
    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    logic                 cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic                 cfg_data  = 1'b0;

    logic              in_valid         = 1'b0;
    logic              in_ready;
    logic              func             = FUNC_PLAY;
    logic [PRIO_W-1:0] request_priority = '0;
    logic [VOL_W-1:0]  request_volume   = '0;
    logic [PAN_W-1:0]  request_pan      = '0;
    logic [CH_W-1:0]   ended_channel    = '0;

    logic              out_valid;
    logic              out_ready = 1'b0;
    logic              granted;
    logic [CH_W-1:0]   channel;
    logic [OVOL_W-1:0] front_volume;
    logic [PAN_W-1:0]  front_pan;
    logic              rear_valid;
    logic [CH_W-1:0]   rear_channel;
    logic [OVOL_W-1:0] rear_volume;
    logic [PAN_W-1:0]  rear_pan;

    // Words waiting to be sent, and the grants the allocator is expected to return.
    voice_word_t  pending_words[$];
    voice_grant_t expected_grants[$];
    voice_word_t  current_word;

    // Our own copy of the allocator state and configuration.
    logic                    eight_mode  = 1'b0;
    logic                    surround_on = 1'b0;
    logic                    mp3_on      = 1'b0;
    logic [NUM_CHANNELS-1:0] chan_busy   = '0;
    logic [PRIO_W-1:0]       chan_prio [NUM_CHANNELS];

    // When idle_on is low, neither side inserts gaps or stalls.
    logic idle_on = 1'b1;
    int   send_gap  = 0;
    int   stall_left = 0;
    int   mismatch_count = 0;

    always #10 clk = ~clk;

    priority_voice_allocator dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .func             (func),
        .request_priority (request_priority),
        .request_volume   (request_volume),
        .request_pan      (request_pan),
        .ended_channel    (ended_channel),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .granted          (granted),
        .channel          (channel),
        .front_volume     (front_volume),
        .front_pan        (front_pan),
        .rear_valid       (rear_valid),
        .rear_channel     (rear_channel),
        .rear_volume      (rear_volume),
        .rear_pan         (rear_pan)
    );

    // Mostly short gaps, now and then a long one.
    function automatic int gap_length();
        int r;
        if (!idle_on)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Channels a play request may not take under the current settings. The top channels
    // beyond the usable count are always out; surround also keeps the upper half of the
    // usable range for rear partners; MP3 keeps channel 0 and its right-hand companion.
    function automatic logic [NUM_CHANNELS-1:0] reserved_channels(input int usable);
        logic [NUM_CHANNELS-1:0] m;
        m = '0;
        for (int i = usable; i < NUM_CHANNELS; i++)
            m[i] = 1'b1;
        if (surround_on)
            for (int i = usable / 2; i < usable; i++)
                m[i] = 1'b1;
        if (mp3_on)
        begin
            m[0] = 1'b1;
            m[surround_on ? usable / 2 : 1] = 1'b1;
        end
        return m;
    endfunction

    function automatic logic [OVOL_W-1:0] limit_volume(input int v);
        if (v < 0)
            return '0;
        if (v > VOL_MAX)
            return OVOL_W'(VOL_MAX);
        return OVOL_W'(v);
    endfunction

    // Works out the grant for one accepted word and updates the channel state.
    function automatic voice_grant_t allocate_voice(input voice_word_t w);
        voice_grant_t            g;
        logic [NUM_CHANNELS-1:0] taken;
        int                      usable, pick, weakest, partner, sv, offset, diff;
        g = '0;
        if (w.func == FUNC_END)
        begin
            chan_busy[w.ended] = 1'b0;
            return g;
        end
        usable = eight_mode ? NUM_CHANNELS / 2 : NUM_CHANNELS;
        taken  = reserved_channels(usable);
        // The highest-numbered free channel wins.
        pick = -1;
        for (int i = 0; i < NUM_CHANNELS; i++)
            if (!taken[i] && !chan_busy[i])
                pick = i;
        // Otherwise steal the first channel holding the lowest priority, if it is not
        // above the request's own.
        if (pick < 0)
        begin
            weakest = -1;
            for (int i = 0; i < NUM_CHANNELS; i++)
                if (!taken[i] && (weakest < 0 || chan_prio[i] < chan_prio[weakest]))
                    weakest = i;
            if (weakest < 0 || chan_prio[weakest] > w.prio)
                return g;
            pick = weakest;
        end
        chan_busy[pick] = 1'b1;
        chan_prio[pick] = w.prio;
        g.granted = 1'b1;
        g.channel = CH_W'(pick);
        if (surround_on)
        begin
            partner = pick + usable / 2;
            sv      = int'(w.vol) * BASE_VOLUME / VOL_FULL;
            // Arithmetic shift gives the floor of the signed pan offset.
            offset  = (int'(w.pan) - PAN_CENTRE) >>> PAN_SHIFT;
            // Signed division truncates toward zero.
            diff    = (offset * sv) / VOL_NORMALIZE;
            if (partner < NUM_CHANNELS)
            begin
                chan_busy[partner] = 1'b1;
                chan_prio[partner] = w.prio;
            end
            g.front_volume = limit_volume(sv + diff);
            g.front_pan    = '0;
            g.rear_valid   = 1'b1;
            g.rear_channel = CH_W'(partner);
            g.rear_volume  = limit_volume(sv - diff);
            g.rear_pan     = PAN_W'(PAN_RIGHT);
        end
        else
        begin
            g.front_volume = OVOL_W'(w.vol);
            g.front_pan    = w.pan;
        end
        return g;
    endfunction

    function automatic voice_word_t play_word(input int prio, input int vol, input int pan);
        voice_word_t w;
        w.func  = FUNC_PLAY;
        w.prio  = PRIO_W'(prio);
        w.vol   = VOL_W'(vol);
        w.pan   = PAN_W'(pan);
        w.ended = CH_W'($urandom);
        return w;
    endfunction

    // The unused fields of an end word still carry random bits.
    function automatic voice_word_t end_word(input int ch);
        voice_word_t w;
        w       = play_word($urandom, $urandom, $urandom);
        w.func  = FUNC_END;
        w.ended = CH_W'(ch);
        return w;
    endfunction

    // Random word: priorities sometimes crowd a narrow band so that ties and equal-priority
    // steals come up; volume and pan hit their ends now and then.
    function automatic voice_word_t random_word(input int end_pct);
        int prio, vol, pan;
        if ($urandom_range(0, 99) < end_pct)
            return end_word($urandom_range(0, NUM_CHANNELS - 1));
        prio = ($urandom_range(0, 3) == 0) ? $urandom_range(100, 104) : $urandom_range(0, 255);
        case ($urandom_range(0, 7))
            0:       vol = 0;
            1:       vol = 127;
            default: vol = $urandom_range(0, 127);
        endcase
        case ($urandom_range(0, 7))
            0:       pan = 0;
            1:       pan = 127;
            2:       pan = $urandom_range(62, 66);
            default: pan = $urandom_range(0, 127);
        endcase
        return play_word(prio, vol, pan);
    endfunction

    task automatic report_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= 50)
            $display("[%0t] MISMATCH: %s", $time, what);
    endtask

    task automatic compare_field(input string name, input int got, input int want);
        if (got != want)
            report_mismatch($sformatf("%s got %0d, expected %0d", name, got, want));
    endtask

    // Registers are only written while the allocator is idle, so the model can follow
    // at once.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        if (idx == CFG_EIGHT)
            eight_mode = val;
        else if (idx == CFG_SURROUND)
            surround_on = val;
        else if (idx == CFG_MP3)
            mp3_on = val;
    endtask

    // Blocks until every queued word has been sent and every grant has come back. The
    // check is made at the falling edge so it never races the clocked blocks.
    task automatic wait_until_drained();
        @(negedge clk);
        while (pending_words.size() != 0 || in_valid || expected_grants.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Settings per phase as {eight-channel, surround, mp3}; both extremes come twice.
    function automatic logic [2:0] phase_setting(input int p);
        case (p)
            0:       return 3'b000;
            1:       return 3'b111;
            2:       return 3'b100;
            3:       return 3'b010;
            4:       return 3'b001;
            5:       return 3'b110;
            6:       return 3'b011;
            7:       return 3'b101;
            8:       return 3'b000;
            9:       return 3'b111;
            10:      return 3'b010;
            default: return 3'b100;
        endcase
    endfunction

    // Driver: presents one word at a time and predicts its grant when it is accepted.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            send_gap <= 0;
        end
        else
        begin
            if (in_valid && in_ready)
                expected_grants.push_back(allocate_voice(current_word));
            if (!in_valid || in_ready)
            begin
                if (send_gap != 0)
                begin
                    in_valid <= 1'b0;
                    send_gap <= send_gap - 1;
                end
                else if (pending_words.size() != 0)
                begin
                    current_word      = pending_words.pop_front();
                    func             <= current_word.func;
                    request_priority <= current_word.prio;
                    request_volume   <= current_word.vol;
                    request_pan      <= current_word.pan;
                    ended_channel    <= current_word.ended;
                    in_valid         <= 1'b1;
                    send_gap         <= gap_length();
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: stalls the output at random and checks each grant against the oldest
    // prediction, field by field.
    always @(posedge clk or negedge rst_n)
    begin
        voice_grant_t want;
        if (!rst_n)
        begin
            out_ready  <= 1'b0;
            stall_left <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_grants.size() == 0)
                begin
                    report_mismatch("grant word arrived with no request outstanding");
                end
                else
                begin
                    want = expected_grants.pop_front();
                    compare_field("granted", int'(granted), int'(want.granted));
                    compare_field("channel", int'(channel), int'(want.channel));
                    compare_field("front_volume", int'(front_volume),
                                  int'(want.front_volume));
                    compare_field("front_pan", int'(front_pan), int'(want.front_pan));
                    compare_field("rear_valid", int'(rear_valid), int'(want.rear_valid));
                    compare_field("rear_channel", int'(rear_channel),
                                  int'(want.rear_channel));
                    compare_field("rear_volume", int'(rear_volume), int'(want.rear_volume));
                    compare_field("rear_pan", int'(rear_pan), int'(want.rear_pan));
                end
            end
            if (stall_left != 0)
            begin
                out_ready  <= 1'b0;
                stall_left <= stall_left - 1;
            end
            else
            begin
                out_ready <= 1'b1;
                if (idle_on && $urandom_range(0, 3) == 0)
                    stall_left <= gap_length();
            end
        end
    end

    // Stimulus: reset, then twelve phases, each with fresh settings written while idle.
    initial
    begin
        logic [2:0] setting;
        int         end_pct;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            wait_until_drained();
            setting = phase_setting(p);
            write_reg(CFG_EIGHT, setting[2]);
            write_reg(CFG_SURROUND, setting[1]);
            write_reg(CFG_MP3, setting[0]);
            // The spare index must not disturb any register.
            if (p == 4)
                write_reg(CFG_UNUSED, 1'b1);
            @(posedge clk);
            cfg_we <= 1'b0;
            // Two phases run with no gaps or stalls at all.
            idle_on = !(p == 3 || p == 8);
            @(negedge clk);
            if (p == 0)
            begin
                // Field extremes with every channel free, then end words at both ends.
                pending_words.push_back(play_word(255, 127, 127));
                pending_words.push_back(play_word(0, 0, 0));
                pending_words.push_back(play_word(128, 64, 64));
                pending_words.push_back(end_word(15));
                pending_words.push_back(end_word(0));
            end
            else if (p == 1)
            begin
                // Only channels 1 to 3 are usable here. Free them, fill them with surround
                // volume extremes, then a lower request is skipped, an equal one steals,
                // a higher one steals the weakest, and a freed channel is reused.
                pending_words.push_back(end_word(1));
                pending_words.push_back(end_word(2));
                pending_words.push_back(end_word(3));
                pending_words.push_back(play_word(10, 127, 0));
                pending_words.push_back(play_word(20, 127, 127));
                pending_words.push_back(play_word(30, 0, 64));
                pending_words.push_back(play_word(5, 64, 1));
                pending_words.push_back(play_word(10, 100, 100));
                pending_words.push_back(play_word(255, 127, 126));
                pending_words.push_back(end_word(2));
                pending_words.push_back(play_word(1, 50, 63));
                pending_words.push_back(end_word(5));
            end
            // Vary how often channels end, so some phases run with every channel busy.
            case (p % 3)
                0:       end_pct = 15;
                1:       end_pct = 35;
                default: end_pct = 55;
            endcase
            for (int i = 0; i < WORDS_PER_PHASE; i++)
                pending_words.push_back(random_word(end_pct));
        end
        wait_until_drained();
        if (mismatch_count == 0)
            $display("** priority_voice_allocator: PASSED **");
        else
            $display("** priority_voice_allocator: FAILED **");
        $finish;
    end

    // Watchdog in case the allocator hangs.
    initial
    begin
        #(TIMEOUT_NS);
        $display("** priority_voice_allocator: FAILED **");
        $finish;
    end

endmodule
